/* design/lfu_pkg.sv */
// Shared types and constants for the LFU cache with LRU tie break.
// Used by lfu_ctrl, lfu_dpath, the top level and the checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package lfu_pkg;

  // Default sizing, handed down as parameters from the top level.
  localparam int unsigned CapacityDef  = 8;
  localparam int unsigned KeyBitsDef   = 16;
  localparam int unsigned CountBitsDef = 16;

  // Fixed port widths.
  localparam int unsigned KeyPortW   = 16;
  localparam int unsigned ValueW     = 32;
  localparam int unsigned CountPortW = 16;

  // Request kinds carried on mode_i.
  localparam logic ModeGet = 1'b0;
  localparam logic ModePut = 1'b1;

  // Controller to datapath commands.
  typedef struct packed {
    logic load_req;  // capture the request beat and clear the match flag
    logic rd_en;     // read one table entry at the scan address
    logic commit;    // write back the accessed entry and load the result register
  } cmd_t;

endpackage

`default_nettype wire

/* design/lfu_ctrl.sv */
// Controller for the LFU cache: accepts a request, sequences the table scan,
// commits the update and owns the output handshake. Depends on lfu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lfu_ctrl #(
  parameter int unsigned CAPACITY = lfu_pkg::CapacityDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output lfu_pkg::cmd_t                      cmd_o,
  output logic [$clog2(CAPACITY)-1:0]        rd_addr_o
);

  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(CAPACITY - 1);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StScan   = 2'd1;
  localparam logic [1:0] StDrain  = 2'd2;
  localparam logic [1:0] StCommit = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            out_valid_q, out_valid_d;
  logic            accept;
  logic            commit;

  assign in_ready_o  = (state_q == StIdle);
  assign accept      = in_valid_i && in_ready_o;
  assign commit      = (state_q == StCommit) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign rd_addr_o   = idx_q;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StScan;
          idx_d   = '0;
        end
      end
      StScan: begin
        if (idx_q == LastIdx) begin
          state_d = StDrain;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      StDrain: begin
        state_d = StCommit;
      end
      StCommit: begin
        if (commit) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Hold the result until taken; a commit refills the register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_comb begin
    cmd_o.load_req = accept;
    cmd_o.rd_en    = (state_q == StScan);
    cmd_o.commit   = commit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

/* design/lfu_dpath.sv */
// Datapath for the LFU cache: entry memory, valid and recency lanes, scan
// for key match and victim, write-back and result register. Depends on lfu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lfu_dpath #(
  parameter int unsigned CAPACITY   = lfu_pkg::CapacityDef,
  parameter int unsigned KEY_BITS   = lfu_pkg::KeyBitsDef,
  parameter int unsigned COUNT_BITS = lfu_pkg::CountBitsDef
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire lfu_pkg::cmd_t                        cmd_i,
  input  wire logic [$clog2(CAPACITY)-1:0]          rd_addr_i,
  input  wire logic                                 mode_i,
  input  wire logic [lfu_pkg::KeyPortW-1:0]         request_key_i,
  input  wire logic signed [lfu_pkg::ValueW-1:0]    write_value_i,
  output logic                                      hit_o,
  output logic signed [lfu_pkg::ValueW-1:0]         read_value_o,
  output logic                                      evicted_o,
  output logic [lfu_pkg::KeyPortW-1:0]              evicted_key_o,
  output logic [lfu_pkg::CountPortW-1:0]            use_count_out_o
);

  localparam int unsigned IdxW  = $clog2(CAPACITY);
  localparam int unsigned RankW = $clog2(CAPACITY);
  localparam int unsigned VW    = lfu_pkg::ValueW;

  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [VW-1:0]         value;
    logic [COUNT_BITS-1:0] count;
  } entry_t;

  // Entry store: one write port, one registered read port.
  entry_t mem [CAPACITY];
  entry_t rdata_q;

  // Per-entry lanes.
  logic [CAPACITY-1:0] valid_q;
  logic [RankW-1:0]    rank_q [CAPACITY];

  // Request.
  logic                  mode_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VW-1:0]         wval_q;

  // Scan pipeline and results.
  logic                  rd_vld_q;
  logic [IdxW-1:0]       rd_idx_q;
  logic                  found_q;
  logic [IdxW-1:0]       hit_idx_q;
  logic [COUNT_BITS-1:0] hit_cnt_q;
  logic [VW-1:0]         hit_val_q;
  logic [RankW-1:0]      hit_rank_q;
  logic [IdxW-1:0]       vic_idx_q;
  logic [COUNT_BITS-1:0] vic_cnt_q;
  logic [RankW-1:0]      vic_rank_q;
  logic [KEY_BITS-1:0]   vic_key_q;

  // Result register.
  logic                        res_hit_q;
  logic [VW-1:0]               res_val_q;
  logic                        res_ev_q;
  logic [lfu_pkg::KeyPortW-1:0]   res_evkey_q;
  logic [lfu_pkg::CountPortW-1:0] res_cnt_q;

  logic                  lane_valid;
  logic [RankW-1:0]      lane_rank;
  logic                  match;
  logic                  better;

  logic                  full;
  logic [IdxW-1:0]       free_idx;
  logic                  we;
  logic                  evict;
  logic                  age_all;
  logic [IdxW-1:0]       slot;
  logic [RankW-1:0]      old_rank;
  entry_t                wdata;

  assign lane_valid = valid_q[rd_idx_q];
  assign lane_rank  = rank_q[rd_idx_q];
  assign match      = lane_valid && (rdata_q.key == key_q);
  assign better     = (rdata_q.count < vic_cnt_q) ||
                      ((rdata_q.count == vic_cnt_q) && (lane_rank > vic_rank_q));

  // Lowest-numbered free entry.
  always_comb begin
    free_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = IdxW'(i);
      end
    end
  end

  assign full = &valid_q;

  // Write-back decision for the accessed entry.
  always_comb begin
    we          = 1'b0;
    evict       = 1'b0;
    age_all     = 1'b0;
    slot        = hit_idx_q;
    old_rank    = hit_rank_q;
    wdata.key   = key_q;
    wdata.value = wval_q;
    wdata.count = COUNT_BITS'(1);
    priority if (found_q) begin
      we          = 1'b1;
      wdata.value = (mode_q == lfu_pkg::ModePut) ? wval_q : hit_val_q;
      wdata.count = (&hit_cnt_q) ? hit_cnt_q : hit_cnt_q + 1'b1;
    end else if (mode_q == lfu_pkg::ModePut) begin
      we = 1'b1;
      if (!full) begin
        slot    = free_idx;
        age_all = 1'b1;
      end else begin
        slot     = vic_idx_q;
        old_rank = vic_rank_q;
        evict    = 1'b1;
      end
    end
  end

  // Memory ports.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rdata_q <= mem[rd_addr_i];
    end
    if (cmd_i.commit && we) begin
      mem[slot] <= wdata;
    end
  end

  // Valid lanes and read pipeline control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.rd_en;
      if (cmd_i.commit && we) begin
        valid_q[slot] <= 1'b1;
      end
    end
  end

  // Recency lanes: the accessed entry becomes most recent, younger ones age.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && we) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (IdxW'(i) == slot) begin
          rank_q[i] <= '0;
        end else if (valid_q[i] && (age_all || (rank_q[i] < old_rank))) begin
          rank_q[i] <= rank_q[i] + 1'b1;
        end
      end
    end
  end

  // Request capture and scan.
  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_addr_i;
    if (cmd_i.load_req) begin
      mode_q  <= mode_i;
      key_q   <= KEY_BITS'(request_key_i);
      wval_q  <= write_value_i;
      found_q <= 1'b0;
    end else if (rd_vld_q) begin
      if (!found_q && match) begin
        found_q    <= 1'b1;
        hit_idx_q  <= rd_idx_q;
        hit_cnt_q  <= rdata_q.count;
        hit_val_q  <= rdata_q.value;
        hit_rank_q <= lane_rank;
      end
      if ((rd_idx_q == '0) || better) begin
        vic_idx_q  <= rd_idx_q;
        vic_cnt_q  <= rdata_q.count;
        vic_rank_q <= lane_rank;
        vic_key_q  <= rdata_q.key;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      res_hit_q   <= found_q;
      res_val_q   <= found_q ? wdata.value : '0;
      res_ev_q    <= evict;
      res_evkey_q <= evict ? lfu_pkg::KeyPortW'(vic_key_q) : '0;
      res_cnt_q   <= we ? lfu_pkg::CountPortW'(wdata.count) : '0;
    end
  end

  assign hit_o           = res_hit_q;
  assign read_value_o    = res_val_q;
  assign evicted_o       = res_ev_q;
  assign evicted_key_o   = res_evkey_q;
  assign use_count_out_o = res_cnt_q;

endmodule

`default_nettype wire

/* design/lfu_cache_lru_tiebreak.sv */
// Top level of the LFU key/value cache with LRU tie break.
// Instantiates lfu_ctrl and lfu_dpath; depends on lfu_pkg.
//
// A small fully associative cache of CAPACITY entries. A get (mode 0) looks
// up request_key_i; a put (mode 1) updates a present key or inserts it,
// filling the lowest free entry or, when the table is full, evicting the
// entry with the lowest use count and, among equal counts, the least
// recently used one. Every request gives exactly one result beat. A request
// streams the entry memory, one entry per cycle, through its single
// registered read port, then drains the last read, then writes back the
// accessed entry and ages the recency ranks in parallel. One request is in
// flight at a time; in_ready_o is high only while the block is idle, so the
// next request is taken at the earliest in the cycle after the write-back.
// The result sits in an output register, so a new request is taken while
// the previous result waits; the write-back cycle holds until that register
// is free. There is no clearing pass: the valid bits reset at once, and key,
// value and count are only trusted for valid entries. Counts saturate at
// 2^COUNT_BITS - 1; only the low KEY_BITS bits of a key take part.
`timescale 1ns / 1ps
`default_nettype none

module lfu_cache_lru_tiebreak #(
  parameter int unsigned CAPACITY   = lfu_pkg::CapacityDef,
  parameter int unsigned KEY_BITS   = lfu_pkg::KeyBitsDef,
  parameter int unsigned COUNT_BITS = lfu_pkg::CountBitsDef
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic                                 mode_i,
  input  wire logic [lfu_pkg::KeyPortW-1:0]         request_key_i,
  input  wire logic signed [lfu_pkg::ValueW-1:0]    write_value_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic                                      hit_o,
  output logic signed [lfu_pkg::ValueW-1:0]         read_value_o,
  output logic                                      evicted_o,
  output logic [lfu_pkg::KeyPortW-1:0]              evicted_key_o,
  output logic [lfu_pkg::CountPortW-1:0]            use_count_out_o
);

  lfu_pkg::cmd_t               cmd;
  logic [$clog2(CAPACITY)-1:0] rd_addr;

  // Sequence the scan and own both handshakes.
  lfu_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .rd_addr_o   (rd_addr)
  );

  // Hold the table, find match and victim, update and present the result.
  lfu_dpath #(
    .CAPACITY   (CAPACITY),
    .KEY_BITS   (KEY_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .rd_addr_i       (rd_addr),
    .mode_i          (mode_i),
    .request_key_i   (request_key_i),
    .write_value_i   (write_value_i),
    .hit_o           (hit_o),
    .read_value_o    (read_value_o),
    .evicted_o       (evicted_o),
    .evicted_key_o   (evicted_key_o),
    .use_count_out_o (use_count_out_o)
  );

endmodule

`default_nettype wire

/* design/lfu_checker.sv */
// Port-level checker for lfu_cache_lru_tiebreak, attached by the bind below.
// Depends on lfu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lfu_checker (
  input wire logic                                 clk_i,
  input wire logic                                 rst_ni,
  input wire logic                                 in_valid_i,
  input wire logic                                 in_ready_o,
  input wire logic                                 out_valid_o,
  input wire logic                                 out_ready_i,
  input wire logic                                 hit_o,
  input wire logic signed [lfu_pkg::ValueW-1:0]    read_value_o,
  input wire logic                                 evicted_o,
  input wire logic [lfu_pkg::KeyPortW-1:0]         evicted_key_o,
  input wire logic [lfu_pkg::CountPortW-1:0]       use_count_out_o
);

  // A stalled result beat holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hit_o) &&
    $stable(read_value_o) && $stable(evicted_o) && $stable(evicted_key_o) &&
    $stable(use_count_out_o))
    else $error("result beat changed while stalled");

  // An accepted request keeps the block busy for its scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while a scan is running");

  // Only a put miss evicts.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && evicted_o |-> !hit_o && use_count_out_o == 1)
    else $error("eviction on a hit or with a wrong count");

  // A get miss reports all zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o && use_count_out_o == 0 |->
    read_value_o == 0 && !evicted_o && evicted_key_o == 0)
    else $error("get miss with nonzero fields");

  // A miss never returns data, and no eviction means no victim key.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> read_value_o == 0 &&
    (evicted_o || evicted_key_o == 0))
    else $error("miss with data or stray victim key");

endmodule

bind lfu_cache_lru_tiebreak lfu_checker u_lfu_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .hit_o           (hit_o),
  .read_value_o    (read_value_o),
  .evicted_o       (evicted_o),
  .evicted_key_o   (evicted_key_o),
  .use_count_out_o (use_count_out_o)
);

`default_nettype wire
